// ----- src/tcw_pkg.sv -----
package tcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Field widths of the stream items
    localparam int MODE_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int CELL_W   = ATTR_W + CHAR_W;
    localparam int OCOL_W   = 7;
    localparam int OROW_W   = 5;
    localparam int IN_BITS  = MODE_W + CHAR_W + ATTR_W + INDEX_W;
    localparam int OUT_BITS = CELL_W + OCOL_W + OROW_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUT   = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_ERASE = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL
    } t_state;

endpackage

// ----- src/text_console_writer_unit.sv -----
// Put, newline and erase land in the output register in the cycle after the transfer,
//   unless a put or newline starts a scroll; a cell read passes the frame RAM read register first.
// Scroll copies every row but the first one row up, then blanks the last row; clear blanks
//   every cell. Both sweep one cell at a time through the single write port of the frame RAM.
// Throughput: one put, newline or erase per cycle while results are taken and no sweep runs; a read holds off input.
// Reset clears the cursor and the handshake state; frame RAM contents are undefined.
module text_console_writer_unit #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata: mode[1:0], char_code[9:2], attribute[17:10], cell_index[28:18], zero pad
    input  logic [tcw_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // Result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata: cell_data[15:0], cursor_col[22:16], cursor_row[27:23], zero pad
    output logic [tcw_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int COPY  = CELLS - COLUMNS;   // cells moved by a scroll
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int CH_W  = tcw_pkg::CHAR_W;
    localparam int AT_W  = tcw_pkg::ATTR_W;

    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [AW-1:0] COPY_END  = AW'(COPY);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] FILL_BOT  = AW'(COPY);

    // Input field unpacking
    tcw_pkg::t_mode                in_mode;
    logic [CH_W-1:0]               in_char;
    logic [AT_W-1:0]               in_attr;
    logic [tcw_pkg::INDEX_W-1:0]   in_idx;

    assign in_mode = tcw_pkg::t_mode'(i_s_axis_tdata[tcw_pkg::MODE_W-1:0]);
    assign in_char = i_s_axis_tdata[tcw_pkg::MODE_W +: CH_W];
    assign in_attr = i_s_axis_tdata[tcw_pkg::MODE_W + CH_W +: AT_W];
    assign in_idx  = i_s_axis_tdata[tcw_pkg::MODE_W + CH_W + AT_W +: tcw_pkg::INDEX_W];

    // State
    tcw_pkg::t_state               r_state, n_state;
    logic [CW-1:0]                 r_col, n_col;
    logic [RW-1:0]                 r_row, n_row;
    logic [AW-1:0]                 r_cnt, n_cnt;
    logic [AT_W-1:0]               r_attr, n_attr;       // blank attribute for sweeps
    logic                          r_rd_ok, n_rd_ok;     // read index in range
    logic                          r_out_valid, n_out_valid;
    logic [tcw_pkg::OUT_BITS-1:0]  r_out_data, n_out_data;

    // Frame RAM access
    logic                          ram_we, ram_re;
    logic [AW-1:0]                 ram_waddr, ram_raddr;
    logic [tcw_pkg::CELL_W-1:0]    ram_wdata, ram_rdata;

    logic                          s_xfer;
    logic                          out_load;
    logic [tcw_pkg::CELL_W-1:0]    out_cell;
    logic                          line_end;   // put or newline moves past the row end
    logic                          need_scroll;
    logic                          at_origin;
    logic [CW-1:0]                 er_col;
    logic [RW-1:0]                 er_row;
    logic [AW-1:0]                 cur_addr, er_addr;
    logic                          idx_ok;

    // Input is taken only when idle and the result register is free or draining
    assign o_s_axis_tready = (r_state == tcw_pkg::ST_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;

    assign line_end    = (in_char == tcw_pkg::NEWLINE_CODE) || (r_col == LAST_COL);
    assign need_scroll = line_end && (r_row == LAST_ROW);
    assign at_origin   = (r_col == '0) && (r_row == '0);

    // Erase target: one cell back, wrapping to the end of the previous row
    assign er_col = (r_col != '0) ? r_col - CW'(1) : LAST_COL;
    assign er_row = (r_col != '0) ? r_row : r_row - RW'(1);

    assign cur_addr = AW'(int'(r_row) * COLUMNS + int'(r_col));
    assign er_addr  = AW'(int'(er_row) * COLUMNS + int'(er_col));
    assign idx_ok   = 32'(in_idx) < 32'(CELLS);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    unique case (in_mode)
                        tcw_pkg::MODE_PUT: begin
                            if (need_scroll) begin
                                n_state = tcw_pkg::ST_SCROLL;
                            end
                        end
                        tcw_pkg::MODE_CLEAR: n_state = tcw_pkg::ST_FILL;
                        tcw_pkg::MODE_ERASE: n_state = tcw_pkg::ST_IDLE;
                        tcw_pkg::MODE_READ:  n_state = tcw_pkg::ST_READ;
                    endcase
                end
            end
            tcw_pkg::ST_READ: n_state = tcw_pkg::ST_IDLE;
            tcw_pkg::ST_SCROLL: begin
                if (r_cnt == COPY_END) begin
                    n_state = tcw_pkg::ST_FILL;
                end
            end
            tcw_pkg::ST_FILL: begin
                if (r_cnt == LAST_CELL) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            default: n_state = tcw_pkg::ST_IDLE;
        endcase
    end

    // Datapath and RAM control
    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_cnt     = r_cnt;
        n_attr    = r_attr;
        n_rd_ok   = r_rd_ok;
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = {in_attr, in_char};
        ram_re    = 1'b0;
        ram_raddr = AW'(in_idx);
        out_load  = 1'b0;
        out_cell  = '0;

        unique case (r_state)
            tcw_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    unique case (in_mode)
                        tcw_pkg::MODE_PUT: begin
                            // newline never writes a cell
                            ram_we = (in_char != tcw_pkg::NEWLINE_CODE);
                            if (line_end) begin
                                n_col = '0;
                                if (need_scroll) begin
                                    n_cnt  = '0;
                                    n_attr = in_attr;
                                end else begin
                                    n_row    = r_row + RW'(1);
                                    out_load = 1'b1;
                                end
                            end else begin
                                n_col    = r_col + CW'(1);
                                out_load = 1'b1;
                            end
                        end
                        tcw_pkg::MODE_CLEAR: begin
                            n_col  = '0;
                            n_row  = '0;
                            n_cnt  = '0;
                            n_attr = in_attr;
                        end
                        tcw_pkg::MODE_ERASE: begin
                            out_load = 1'b1;
                            if (!at_origin) begin
                                n_col     = er_col;
                                n_row     = er_row;
                                ram_we    = 1'b1;
                                ram_waddr = er_addr;
                                ram_wdata = {in_attr, tcw_pkg::SPACE_CODE};
                            end
                        end
                        tcw_pkg::MODE_READ: begin
                            ram_re  = idx_ok;
                            n_rd_ok = idx_ok;
                        end
                    endcase
                end
            end
            tcw_pkg::ST_READ: begin
                out_load = 1'b1;
                out_cell = r_rd_ok ? ram_rdata : '0;
            end
            tcw_pkg::ST_SCROLL: begin
                // read row below, write the registered read data one row up
                ram_re    = (r_cnt != COPY_END);
                ram_raddr = r_cnt + AW'(COLUMNS);
                ram_we    = (r_cnt != '0);
                ram_waddr = r_cnt - AW'(1);
                ram_wdata = ram_rdata;
                n_cnt     = (r_cnt == COPY_END) ? FILL_BOT : r_cnt + AW'(1);
            end
            tcw_pkg::ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = {r_attr, tcw_pkg::SPACE_CODE};
                n_cnt     = r_cnt + AW'(1);
                out_load  = (r_cnt == LAST_CELL);
            end
            default: ;
        endcase
    end

    // Result register: loads only when free or draining (guaranteed by o_s_axis_tready)
    always_comb begin
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_data  = {tcw_pkg::OROW_W'(n_row), tcw_pkg::OCOL_W'(n_col), out_cell};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_attr     <= n_attr;
        r_rd_ok    <= n_rd_ok;
        r_out_data <= n_out_data;
    end

    tcw_frame_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(tcw_pkg::OUT_TDATA_W - tcw_pkg::OUT_BITS){1'b0}}, r_out_data};

`ifndef NO_ASSERTIONS
    // Cursor always stays on screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col) < 32'(COLUMNS)) && (32'(r_row) < 32'(ROWS)))
        else $error("cursor left the screen");

    // A scroll parks the cursor at the start of the last row
    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::ST_SCROLL) |-> (r_row == LAST_ROW) && (r_col == '0))
        else $error("cursor not parked during scroll");

    // Scroll sweep never runs past the copy region
    a_scroll_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::ST_SCROLL) |-> (r_cnt <= COPY_END))
        else $error("scroll counter overran");

    // A pending result is never overwritten before it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !out_load)
        else $error("result register overwritten");

    // A cell read completes with the result register empty
    a_sweep_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::ST_READ) |-> !r_out_valid)
        else $error("result register busy at read completion");
`endif

endmodule

// ----- src/tcw_frame_ram.sv -----
module tcw_frame_ram #(
    parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [tcw_pkg::CELL_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [AW-1:0]               i_raddr,
    output logic [tcw_pkg::CELL_W-1:0]  o_rdata
);

    logic [tcw_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [tcw_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
